// ===== sv/irsd_pkg.sv =====
// Shared types, register offsets and helpers for the internal RAM and SFR decoder.
// No dependencies; every other file imports this package.
`default_nettype none
package irsd_pkg;

  localparam int unsigned RamBytes = 256;
  localparam int unsigned RamWords = RamBytes / 2;
  localparam int unsigned RamAw    = $clog2(RamWords);

  localparam logic [19:0] ADDR_TOP = 20'hFFFFF;
  localparam logic [2:0]  WIN_LOW  = 3'b111;

  localparam logic OP_WRITE = 1'b1;

  // SFR offsets, relative to the start of the SFR page
  localparam logic [7:0] SFR_P0    = 8'h00;
  localparam logic [7:0] SFR_P1    = 8'h08;
  localparam logic [7:0] SFR_P2    = 8'h10;
  localparam logic [7:0] SFR_PT    = 8'h38;
  localparam logic [7:0] SFR_EXIC0 = 8'h4C;
  localparam logic [7:0] SFR_EXIC1 = 8'h4D;
  localparam logic [7:0] SFR_EXIC2 = 8'h4E;
  localparam logic [7:0] SFR_TM0   = 8'h80;
  localparam logic [7:0] SFR_MD0   = 8'h82;
  localparam logic [7:0] SFR_TM1   = 8'h88;
  localparam logic [7:0] SFR_MD1   = 8'h8A;
  localparam logic [7:0] SFR_TMC0  = 8'h90;
  localparam logic [7:0] SFR_TMC1  = 8'h91;
  localparam logic [7:0] SFR_TMIC0 = 8'h9C;
  localparam logic [7:0] SFR_TMIC1 = 8'h9D;
  localparam logic [7:0] SFR_TMIC2 = 8'h9E;
  localparam logic [7:0] SFR_FLAG  = 8'hEA;
  localparam logic [7:0] SFR_PRC   = 8'hEB;
  localparam logic [7:0] SFR_TBIC  = 8'hEC;
  localparam logic [7:0] SFR_IRQS  = 8'hEF;
  localparam logic [7:0] SFR_ISPR  = 8'hFC;
  localparam logic [7:0] SFR_IDB   = 8'hFF;

  // timer word registers
  localparam logic [1:0] TW_TM0 = 2'd0;
  localparam logic [1:0] TW_MD0 = 2'd1;
  localparam logic [1:0] TW_TM1 = 2'd2;
  localparam logic [1:0] TW_MD1 = 2'd3;

  localparam logic [1:0] TIMER_TB = 2'd3;

  typedef enum logic [2:0] {
    KIND_DONE   = 3'd0,
    KIND_EXT_WR = 3'd1,
    KIND_PORT   = 3'd2,
    KIND_TSTART = 3'd3,
    KIND_TSTOP  = 3'd4
  } kind_e;

  typedef struct packed {
    logic        opcode;
    logic        is_word;
    logic [19:0] address;
    logic [15:0] write_data;
    logic [31:0] port_levels;
    logic [15:0] ext_read_data;
    logic [3:0]  line_levels;
    logic [7:0]  irq_status;
    logic [7:0]  in_service;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [19:0] mem_address;
    logic [7:0]  byte_value;
    logic [1:0]  port_index;
    logic [1:0]  timer_index;
    logic [25:0] timer_period;
    logic        timer_repeat;
    logic [15:0] read_data;
    logic        last;
  } out_word_t;

  // up to two side effects of one byte step
  typedef struct packed {
    out_word_t   ev0;
    out_word_t   ev1;
    logic [1:0]  cnt;
  } ev_pair_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] offset;
    logic [7:0] data;
  } sfr_req_t;

  typedef struct packed {
    logic        wr_en;
    logic [1:0]  idx;
    logic [15:0] data;
  } tw_req_t;

  function automatic out_word_t mk_ev(input kind_e k, input logic [19:0] addr,
                                      input logic [7:0] b, input logic [1:0] port,
                                      input logic [1:0] tidx, input logic [25:0] per,
                                      input logic rep);
    out_word_t w;
    w.kind         = k;
    w.mem_address  = addr;
    w.byte_value   = b;
    w.port_index   = port;
    w.timer_index  = tidx;
    w.timer_period = per;
    w.timer_repeat = rep;
    w.read_data    = 16'h0;
    w.last         = 1'b0;
    return w;
  endfunction

  function automatic logic [4:0] tb_shift(input logic [1:0] code);
    logic [4:0] s;
    case (code)
      2'd0:    s = 5'd10;
      2'd1:    s = 5'd13;
      2'd2:    s = 5'd16;
      default: s = 5'd20;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/irsd_ram.sv =====
// Internal data RAM: 128 x 16, one write port, one read port with registered data.
// Depends on irsd_pkg.
`default_nettype none
module irsd_ram import irsd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [RamAw-1:0]  waddr_i,
  input  wire logic [15:0]       wdata_i,
  input  wire logic              re_i,
  input  wire logic [RamAw-1:0]  raddr_i,
  output logic      [15:0]       rdata_o
);

  logic [15:0] mem [RamWords];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/irsd_sfr.sv =====
// Special function registers: interrupt control, flags, PRC, IDB and timers.
// Byte read mux, byte write side effects and timer word access. Depends on irsd_pkg.
`default_nettype none
module irsd_sfr import irsd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sfr_req_t req_i,
  input  wire tw_req_t  tw_i,
  input  wire in_word_t item_i,
  output logic [7:0]    rdata_o,
  output logic [15:0]   tw_rdata_o,
  output ev_pair_t      ev_o,
  output logic [7:0]    window_base_o,
  output logic          ram_en_o
);

  logic [7:0]  wb_q, wb_d;
  logic        ren_q, ren_d;
  logic [1:0]  tbc_q, tbc_d;
  logic [1:0]  cdc_q, cdc_d;
  logic [1:0]  flags_q, flags_d;
  logic [6:0]  pend_q, pend_d;
  logic [6:0]  unm_q, unm_d;
  logic [6:0]  bank_q, bank_d;
  logic [2:0]  eprio_q, eprio_d;
  logic [2:0]  tprio_q, tprio_d;
  logic [15:0] tcnt_q [2];
  logic [15:0] tcnt_d [2];
  logic [15:0] tmod_q [2];
  logic [15:0] tmod_d [2];

  function automatic logic [25:0] tperiod(input logic [15:0] m, input logic [1:0] cd,
                                          input logic big, input logic half);
    logic [31:0] b;
    logic [31:0] p;
    b = (32'(m) << 1) << cd;
    if (big) p = b << 7;
    else if (half) p = (b << 2) + (b << 1);
    else p = (b << 3) + (b << 2);
    return p[25:0];
  endfunction

  function automatic logic [7:0] irq_rd(input logic p, input logic u, input logic k,
                                        input logic [2:0] prio);
    return {p, ~u, 1'b0, k, 1'b0, prio};
  endfunction

  assign window_base_o = wb_q;
  assign ram_en_o      = ren_q;

  // byte read mux
  always_comb begin
    rdata_o = 8'h00;
    unique case (req_i.offset)
      SFR_P0:    rdata_o = item_i.port_levels[7:0];
      SFR_P1:    rdata_o = {item_i.port_levels[15:12], ~item_i.line_levels};
      SFR_P2:    rdata_o = item_i.port_levels[23:16];
      SFR_PT:    rdata_o = item_i.port_levels[31:24];
      SFR_EXIC0: rdata_o = irq_rd(pend_q[0], unm_q[0], bank_q[0], eprio_q);
      SFR_EXIC1: rdata_o = irq_rd(pend_q[1], unm_q[1], bank_q[1], 3'd7);
      SFR_EXIC2: rdata_o = irq_rd(pend_q[2], unm_q[2], bank_q[2], 3'd7);
      SFR_TMIC0: rdata_o = irq_rd(pend_q[3], unm_q[3], bank_q[3], tprio_q);
      SFR_TMIC1: rdata_o = irq_rd(pend_q[4], unm_q[4], bank_q[4], 3'd7);
      SFR_TMIC2: rdata_o = irq_rd(pend_q[5], unm_q[5], bank_q[5], 3'd7);
      SFR_FLAG:  rdata_o = {2'b00, flags_q[1], 1'b0, flags_q[0], 3'b000};
      SFR_PRC:   rdata_o = {1'b0, ren_q, 2'b00, tbc_q, cdc_q};
      SFR_TBIC:  rdata_o = irq_rd(pend_q[6], unm_q[6], bank_q[6], 3'd7);
      SFR_IRQS:  rdata_o = item_i.irq_status;
      SFR_ISPR:  rdata_o = item_i.in_service;
      SFR_IDB:   rdata_o = wb_q;
      default:   rdata_o = 8'h00;
    endcase
  end

  always_comb begin
    unique case (tw_i.idx)
      TW_TM0:  tw_rdata_o = tcnt_q[0];
      TW_MD0:  tw_rdata_o = tmod_q[0];
      TW_TM1:  tw_rdata_o = tcnt_q[1];
      default: tw_rdata_o = tmod_q[1];
    endcase
  end

  // write side effects
  always_comb begin
    logic [7:0]  d;
    logic [1:0]  cd_new;
    logic [31:0] tb_per;
    d       = req_i.data;
    cd_new  = (d[1:0] == 2'd3) ? 2'd2 : d[1:0];
    tb_per  = (32'd2 << cd_new) << tb_shift(d[3:2]);
    wb_d    = wb_q;
    ren_d   = ren_q;
    tbc_d   = tbc_q;
    cdc_d   = cdc_q;
    flags_d = flags_q;
    pend_d  = pend_q;
    unm_d   = unm_q;
    bank_d  = bank_q;
    eprio_d = eprio_q;
    tprio_d = tprio_q;
    tcnt_d  = tcnt_q;
    tmod_d  = tmod_q;
    ev_o    = '0;
    if (req_i.wr_en) begin
      unique case (req_i.offset)
        SFR_P0: begin
          ev_o.ev0 = mk_ev(KIND_PORT, 20'h0, d, 2'd0, 2'd0, 26'h0, 1'b0);
          ev_o.cnt = 2'd1;
        end
        SFR_P1: begin
          ev_o.ev0 = mk_ev(KIND_PORT, 20'h0, {d[7:4], 4'h0}, 2'd1, 2'd0, 26'h0, 1'b0);
          ev_o.cnt = 2'd1;
        end
        SFR_P2: begin
          ev_o.ev0 = mk_ev(KIND_PORT, 20'h0, d, 2'd2, 2'd0, 26'h0, 1'b0);
          ev_o.cnt = 2'd1;
        end
        SFR_EXIC0, SFR_EXIC1, SFR_EXIC2, SFR_TMIC0, SFR_TMIC1, SFR_TMIC2, SFR_TBIC: begin
          logic [2:0] i;
          logic [7:0] dd;
          dd = d;
          case (req_i.offset)
            SFR_EXIC0: i = 3'd0;
            SFR_EXIC1: i = 3'd1;
            SFR_EXIC2: i = 3'd2;
            SFR_TMIC0: i = 3'd3;
            SFR_TMIC1: i = 3'd4;
            SFR_TMIC2: i = 3'd5;
            default: begin
              i  = 3'd6;
              dd = d & 8'hC0;   // bank switching stays off for the time base
            end
          endcase
          pend_d[i] = dd[7];
          unm_d[i]  = ~dd[6];
          bank_d[i] = dd[4];
          if (req_i.offset == SFR_EXIC0) eprio_d = d[2:0];
          if (req_i.offset == SFR_TMIC0) tprio_d = d[2:0];
        end
        SFR_TMC0: begin
          ev_o.cnt = 2'd2;
          if (d[0]) begin
            ev_o.ev0 = d[7]
              ? mk_ev(KIND_TSTART, 20'h0, 8'h0, 2'd0, 2'd0,
                      tperiod(tcnt_q[0], cdc_q, d[6], 1'b0), 1'b0)
              : mk_ev(KIND_TSTOP, 20'h0, 8'h0, 2'd0, 2'd0, 26'h0, 1'b0);
            ev_o.ev1 = d[5]
              ? mk_ev(KIND_TSTART, 20'h0, 8'h0, 2'd0, 2'd1,
                      tperiod(tmod_q[0], cdc_q, d[4], 1'b0), 1'b0)
              : mk_ev(KIND_TSTOP, 20'h0, 8'h0, 2'd0, 2'd1, 26'h0, 1'b0);
          end else if (d[7]) begin
            ev_o.ev0 = mk_ev(KIND_TSTART, 20'h0, 8'h0, 2'd0, 2'd0,
                             tperiod(tmod_q[0], cdc_q, d[6], 1'b1), 1'b1);
            ev_o.ev1 = mk_ev(KIND_TSTOP, 20'h0, 8'h0, 2'd0, 2'd1, 26'h0, 1'b0);
            tcnt_d[0] = tmod_q[0];
          end else begin
            ev_o.ev0 = mk_ev(KIND_TSTOP, 20'h0, 8'h0, 2'd0, 2'd0, 26'h0, 1'b0);
            ev_o.ev1 = mk_ev(KIND_TSTOP, 20'h0, 8'h0, 2'd0, 2'd1, 26'h0, 1'b0);
          end
        end
        SFR_TMC1: begin
          ev_o.cnt = 2'd1;
          if (d[7]) begin
            ev_o.ev0 = mk_ev(KIND_TSTART, 20'h0, 8'h0, 2'd0, 2'd2,
                             tperiod(tmod_q[1], cdc_q, d[6], 1'b1), 1'b1);
            tcnt_d[1] = tmod_q[1];
          end else begin
            ev_o.ev0 = mk_ev(KIND_TSTOP, 20'h0, 8'h0, 2'd0, 2'd2, 26'h0, 1'b0);
          end
        end
        SFR_FLAG: flags_d = {d[5], d[3]};
        SFR_PRC: begin
          ren_d    = d[6];
          tbc_d    = d[3:2];
          cdc_d    = cd_new;
          ev_o.ev0 = mk_ev(KIND_TSTART, 20'h0, 8'h0, 2'd0, TIMER_TB, tb_per[25:0], 1'b1);
          ev_o.cnt = 2'd1;
        end
        SFR_IDB: wb_d = d;
        default: ;
      endcase
    end
    if (tw_i.wr_en) begin
      unique case (tw_i.idx)
        TW_TM0:  tcnt_d[0] = tw_i.data;
        TW_MD0:  tmod_d[0] = tw_i.data;
        TW_TM1:  tcnt_d[1] = tw_i.data;
        default: tmod_d[1] = tw_i.data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q    <= 8'hFF;
      ren_q   <= 1'b1;
      tbc_q   <= 2'd3;
      cdc_q   <= 2'd2;
      flags_q <= 2'd0;
      pend_q  <= '0;
      unm_q   <= '0;
      bank_q  <= '0;
      eprio_q <= 3'd7;
      tprio_q <= 3'd7;
      tcnt_q  <= '{default: 16'h0};
      tmod_q  <= '{default: 16'h0};
    end else begin
      wb_q    <= wb_d;
      ren_q   <= ren_d;
      tbc_q   <= tbc_d;
      cdc_q   <= cdc_d;
      flags_q <= flags_d;
      pend_q  <= pend_d;
      unm_q   <= unm_d;
      bank_q  <= bank_d;
      eprio_q <= eprio_d;
      tprio_q <= tprio_d;
      tcnt_q  <= tcnt_d;
      tmod_q  <= tmod_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/internal_ram_and_sfr_bus_decoder_core.sv =====
// Top level of the internal RAM and SFR bus decoder: access sequencer and output register.
// Depends on irsd_pkg, irsd_ram and irsd_sfr.
//
// Usage: one bus access enters as a word on the input channel (in_valid_i, in_stall_o,
// in_word_i). The block answers with one to four words on the output channel
// (out_valid_o, out_stall_i, out_word_o): port writes, external byte writes and
// timer start or stop commands in program order, then one completion word with
// last set and the read data.
// An access is worked as byte steps. A byte access is one step; a word access is
// two (address, then address plus one), except an even word to TM0, MD0, TM1 or MD1.
// Each step reads the RAM word in one cycle and merges and writes back in the next,
// so RAM read-modify-write needs no forwarding: the next read is issued later.
// Each byte step passes the address, execute and emit check states; the completion
// is then loaded from the done state, and each side-effect word is loaded from the
// emit state. An even timer word access goes from the address state straight to done.
// The block takes one access at a time; the next access can be taken in the cycle
// after the completion is loaded, even while the completion waits.
// A stalled receiver holds the output register; the emit and done states wait with it.
// Reset returns the sequencer state, the output valid flag and the SFRs to their defaults;
// RAM contents are undefined until written.
`default_nettype none
module internal_ram_and_sfr_bus_decoder_core import irsd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_EMIT,
    ST_DONE
  } state_e;

  state_e      state_q;
  in_word_t    item_q;
  logic        step_q;
  logic [15:0] rd_q;
  ev_pair_t    ev_q;
  logic [1:0]  ev_idx_q;
  logic        out_valid_q;
  out_word_t   out_q;

  logic [19:0] cur_addr;
  logic [8:0]  off;
  logic [7:0]  wbyte;
  logic        is_wr;
  logic        win_hit;
  logic        hit;
  logic        ram_sel;
  logic        sfr_sel;
  logic        tw_hit;
  logic [1:0]  tw_idx;
  logic [15:0] ram_rdata;
  logic [7:0]  sfr_rdata;
  logic [15:0] tw_rdata;
  logic [7:0]  window_base;
  logic        ram_en;
  logic        out_free;
  logic        out_load;
  logic [7:0]  rd_byte;
  ev_pair_t    sfr_ev;
  ev_pair_t    step_ev;
  out_word_t   done_word;
  sfr_req_t    sfr_req;
  tw_req_t     tw_req;

  // Decode the current byte step against the live window and RAM enable.
  assign cur_addr = step_q ? (item_q.address + 20'd1) : item_q.address;
  assign off      = cur_addr[8:0];
  assign wbyte    = step_q ? item_q.write_data[15:8] : item_q.write_data[7:0];
  assign is_wr    = (item_q.opcode == OP_WRITE);
  assign win_hit  = (cur_addr[19:9] == {window_base, WIN_LOW});
  assign hit      = win_hit || (cur_addr == ADDR_TOP);
  assign ram_sel  = hit && ram_en && !off[8];
  assign sfr_sel  = hit && off[8];
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free && (((state_q == ST_EMIT) && (ev_idx_q < ev_q.cnt)) ||
                                 (state_q == ST_DONE));

  // Even word to a timer count or modulus goes straight to the 16-bit register.
  always_comb begin
    tw_idx = TW_TM0;
    tw_hit = 1'b0;
    if (item_q.is_word && !step_q && !cur_addr[0] && win_hit && off[8]) begin
      unique case (off[7:0])
        SFR_TM0: begin tw_idx = TW_TM0; tw_hit = 1'b1; end
        SFR_MD0: begin tw_idx = TW_MD0; tw_hit = 1'b1; end
        SFR_TM1: begin tw_idx = TW_TM1; tw_hit = 1'b1; end
        SFR_MD1: begin tw_idx = TW_MD1; tw_hit = 1'b1; end
        default: ;
      endcase
    end
  end

  assign tw_req.wr_en = (state_q == ST_ADDR) && tw_hit && is_wr;
  assign tw_req.idx   = tw_idx;
  assign tw_req.data  = item_q.write_data;

  assign sfr_req.wr_en  = (state_q == ST_EXEC) && is_wr && sfr_sel;
  assign sfr_req.offset = off[7:0];
  assign sfr_req.data   = wbyte;

  irsd_ram u_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_EXEC) && is_wr && ram_sel),
    .waddr_i (off[RamAw:1]),
    .wdata_i (off[0] ? {wbyte, ram_rdata[7:0]} : {ram_rdata[15:8], wbyte}),
    .re_i    (state_q == ST_ADDR),
    .raddr_i (off[RamAw:1]),
    .rdata_o (ram_rdata)
  );

  irsd_sfr u_sfr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (sfr_req),
    .tw_i          (tw_req),
    .item_i        (item_q),
    .rdata_o       (sfr_rdata),
    .tw_rdata_o    (tw_rdata),
    .ev_o          (sfr_ev),
    .window_base_o (window_base),
    .ram_en_o      (ram_en)
  );

  // Read byte and side effects of the current step.
  always_comb begin
    if (ram_sel) begin
      rd_byte = off[0] ? ram_rdata[15:8] : ram_rdata[7:0];
    end else if (sfr_sel) begin
      rd_byte = sfr_rdata;
    end else begin
      rd_byte = step_q ? item_q.ext_read_data[15:8] : item_q.ext_read_data[7:0];
    end
    step_ev = '0;
    if (is_wr) begin
      if (sfr_sel) begin
        step_ev = sfr_ev;
      end else if (!ram_sel) begin
        step_ev.ev0 = mk_ev(KIND_EXT_WR, cur_addr, wbyte, 2'd0, 2'd0, 26'h0, 1'b0);
        step_ev.cnt = 2'd1;
      end
    end
  end

  // Completion word: read data for a read, zero for a write.
  always_comb begin
    done_word           = mk_ev(KIND_DONE, 20'h0, 8'h0, 2'd0, 2'd0, 26'h0, 1'b0);
    done_word.read_data = is_wr ? 16'h0 : rd_q;
    done_word.last      = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 1'b0;
      ev_idx_q    <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new output word, or drop the old one once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_word_i;
            step_q  <= 1'b0;
            rd_q    <= 16'h0;
            state_q <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (tw_hit) begin
            if (!is_wr) rd_q <= tw_rdata;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!is_wr) begin
            if (step_q) rd_q[15:8] <= rd_byte;
            else rd_q[7:0] <= rd_byte;
          end
          ev_q     <= step_ev;
          ev_idx_q <= 2'd0;
          state_q  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (ev_idx_q < ev_q.cnt) begin
            if (out_free) begin
              out_q    <= (ev_idx_q == 2'd0) ? ev_q.ev0 : ev_q.ev1;
              ev_idx_q <= ev_idx_q + 2'd1;
            end
          end else if (item_q.is_word && !step_q) begin
            step_q  <= 1'b1;
            state_q <= ST_ADDR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_q   <= done_word;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire
